@@ design/binary_min_heap_queue_unit_assert.svh @@
// Assertion macros for the heap queue unit checker.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef BINARY_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define BMHQ_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bmhq: property violated");

// next-cycle implication
`define BMHQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bmhq: property violated");

`endif

@@ design/bmhq_pkg.sv @@
// Shared types and constants for the binary min-heap queue unit.
// No dependencies.
package bmhq_pkg;

    localparam int unsigned CAPACITY_DEF = 256;
    localparam int unsigned KEY_W        = 32;
    localparam int unsigned TAG_W        = 16;
    localparam int unsigned KIND_W       = 2;
    localparam int unsigned STAT_W       = 2;
    localparam int unsigned OCC_W        = 9;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 2'd0,
        KIND_EXTRACT = 2'd1,
        KIND_LOAD    = 2'd2,
        KIND_BUILD   = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_EX_ROOT,
        S_EX_LAST,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_BLD_NEXT,
        S_BLD_LD,
        S_DONE
    } t_state;

endpackage

@@ design/bmhq_if.sv @@
// Valid/ready channel interfaces for the heap queue unit: request and result.
// Depends on bmhq_pkg.
interface bmhq_in_if
    import bmhq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;

    modport source (output valid, output kind, output key, output tag, input ready);
    modport sink   (input valid, input kind, input key, input tag, output ready);
endinterface

interface bmhq_out_if
    import bmhq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  out_key;
    logic [TAG_W-1:0]  out_tag;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, output out_key, output out_tag, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input out_key, input out_tag, input status,
                    input occupancy, output ready);
endinterface

@@ design/binary_min_heap_queue_unit.sv @@
// Binary min-heap priority queue of (key, tag) entries held in one on-chip memory with a
// single write port and one registered read port; a small sequencer and one key comparator
// walk the tree. Busy for one item at a time. Load, refused items and build on fewer than two
// entries finish without walking the tree; insert moves the new entry up level by level
// toward the root, extract sinks the last entry down from the root, and build sinks each of
// count/2 parents in turn. A finished result sits in an output register, so the next item
// may be taken while it waits.
// Depends on bmhq_pkg and bmhq_if.
module binary_min_heap_queue_unit
    import bmhq_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmhq_in_if.sink     i_in,
    bmhq_out_if.source  o_res
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = AW + 2;

    t_entry r_mem [CAPACITY];

    t_state            r_state, n_state;
    t_kind             r_kind, n_kind;
    t_entry            r_new, n_new;
    t_entry            r_cur, n_cur;
    t_entry            r_best, n_best;
    logic [AW-1:0]     r_best_idx, n_best_idx;
    logic              r_best_child, n_best_child;
    logic [AW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_bidx, n_bidx;
    logic [CW-1:0]     r_count, n_count;
    t_entry            r_res, n_res;
    t_status           r_status, n_status;
    t_entry            r_rd_data;

    logic              r_out_valid, n_out_valid;
    t_entry            r_out_res, n_out_res;
    t_status           r_out_status, n_out_status;
    logic [OCC_W-1:0]  r_out_occ, n_out_occ;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    t_entry            w_wdata;
    logic [AW-1:0]     w_raddr;

    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    logic [IW-1:0]     w_left;
    logic [IW-1:0]     w_right;
    logic              w_left_ok;
    logic              w_right_ok;
    logic [AW-1:0]     w_parent;
    logic [KEY_W-1:0]  w_cmp_a;
    logic [KEY_W-1:0]  w_cmp_b;
    logic              w_less;
    logic              w_fin_child;
    t_entry            w_fin_entry;
    logic [AW-1:0]     w_fin_idx;
    t_state            w_end_state;
    t_entry            w_in_entry;

    assign i_in.ready      = (r_state == S_IDLE);
    assign w_accept        = i_in.valid && i_in.ready;
    assign w_in_entry      = '{key: i_in.key, tag: i_in.tag};

    assign o_res.valid     = r_out_valid;
    assign o_res.out_key   = r_out_res.key;
    assign o_res.out_tag   = r_out_res.tag;
    assign o_res.status    = r_out_status;
    assign o_res.occupancy = r_out_occ;

    assign w_full      = (r_count >= CW'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_left      = IW'({r_pos, 1'b1});
    assign w_right     = w_left + IW'(1);
    assign w_left_ok   = (w_left < IW'(r_count));
    assign w_right_ok  = (w_right < IW'(r_count));
    assign w_parent    = AW'((r_pos - AW'(1)) >> 1);
    assign w_end_state = (r_kind == KIND_BUILD) ? S_BLD_NEXT : S_DONE;

    // shared key comparator
    always_comb begin
        case (r_state)
            S_UP_CMP: begin
                w_cmp_a = r_new.key;
                w_cmp_b = r_rd_data.key;
            end
            S_DN_R: begin
                w_cmp_a = r_rd_data.key;
                w_cmp_b = r_cur.key;
            end
            S_DN_CMP: begin
                w_cmp_a = r_rd_data.key;
                w_cmp_b = r_best.key;
            end
            default: begin
                w_cmp_a = '0;
                w_cmp_b = '0;
            end
        endcase
    end

    assign w_less = (w_cmp_a < w_cmp_b);

    // smallest of current, left and right; ties keep the current entry, then left
    always_comb begin
        if (r_state == S_DN_CMP) begin
            if (w_less) begin
                w_fin_child = 1'b1;
                w_fin_entry = r_rd_data;
                w_fin_idx   = w_right[AW-1:0];
            end else begin
                w_fin_child = r_best_child;
                w_fin_entry = r_best;
                w_fin_idx   = r_best_idx;
            end
        end else begin
            w_fin_child = w_less;
            w_fin_entry = w_less ? r_rd_data : r_cur;
            w_fin_idx   = w_left[AW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_kind'(i_in.kind))
                        KIND_INSERT:  n_state = w_full ? S_DONE : S_UP_CHK;
                        KIND_EXTRACT: n_state = w_empty ? S_DONE : S_EX_ROOT;
                        KIND_LOAD:    n_state = S_DONE;
                        KIND_BUILD:   n_state = ((r_count >> 1) == '0) ? S_DONE : S_BLD_NEXT;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_UP_CHK:   n_state = (r_pos == '0) ? S_DONE : S_UP_CMP;
            S_UP_CMP:   n_state = w_less ? S_UP_CHK : S_DONE;
            S_EX_ROOT:  n_state = S_EX_LAST;
            S_EX_LAST:  n_state = S_DN_L;
            S_DN_L:     n_state = w_left_ok ? S_DN_R : w_end_state;
            S_DN_R: begin
                if (w_right_ok) begin
                    n_state = S_DN_CMP;
                end else begin
                    n_state = w_fin_child ? S_DN_L : w_end_state;
                end
            end
            S_DN_CMP:   n_state = w_fin_child ? S_DN_L : w_end_state;
            S_BLD_NEXT: n_state = (r_bidx == '0) ? S_DONE : S_BLD_LD;
            S_BLD_LD:   n_state = S_DN_L;
            S_DONE:     n_state = (!r_out_valid || o_res.ready) ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_kind       = r_kind;
        n_new        = r_new;
        n_cur        = r_cur;
        n_best       = r_best;
        n_best_idx   = r_best_idx;
        n_best_child = r_best_child;
        n_pos        = r_pos;
        n_bidx       = r_bidx;
        n_count      = r_count;
        n_res        = r_res;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_res    = r_out_res;
        n_out_status = r_out_status;
        n_out_occ    = r_out_occ;
        w_we         = 1'b0;
        w_waddr      = r_pos;
        w_wdata      = r_cur;
        w_raddr      = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind   = t_kind'(i_in.kind);
                    n_new    = w_in_entry;
                    n_res    = '0;
                    n_status = ST_OK;
                    case (t_kind'(i_in.kind))
                        KIND_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_pos   = AW'(r_count);
                                n_count = r_count + CW'(1);
                            end
                        end
                        KIND_LOAD: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = AW'(r_count);
                                w_wdata = w_in_entry;
                                n_count = r_count + CW'(1);
                            end
                        end
                        KIND_EXTRACT: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        KIND_BUILD: n_bidx = AW'(r_count >> 1);
                        default: ;
                    endcase
                end
            end
            S_UP_CHK: begin
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    w_wdata = r_new;
                end else begin
                    w_raddr = w_parent;
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if (w_less) begin
                    w_wdata = r_rd_data;
                    n_pos   = w_parent;
                end else begin
                    w_wdata = r_new;
                end
            end
            S_EX_ROOT: begin
                n_res   = r_rd_data;
                w_raddr = AW'(r_count - CW'(1));
                n_count = r_count - CW'(1);
            end
            S_EX_LAST: begin
                n_cur = r_rd_data;
                n_pos = '0;
            end
            S_DN_L: begin
                if (w_left_ok) begin
                    w_raddr = w_left[AW-1:0];
                end else begin
                    w_we = 1'b1;
                end
            end
            S_DN_R, S_DN_CMP: begin
                n_best       = w_fin_entry;
                n_best_idx   = w_fin_idx;
                n_best_child = w_fin_child;
                if ((r_state == S_DN_R) && w_right_ok) begin
                    w_raddr = w_right[AW-1:0];
                end else if (w_fin_child) begin
                    w_we    = 1'b1;
                    w_wdata = w_fin_entry;
                    n_pos   = w_fin_idx;
                end else begin
                    w_we = 1'b1;
                end
            end
            S_BLD_NEXT: begin
                if (r_bidx != '0) begin
                    w_raddr = r_bidx - AW'(1);
                    n_pos   = r_bidx - AW'(1);
                    n_bidx  = r_bidx - AW'(1);
                end
            end
            S_BLD_LD: n_cur = r_rd_data;
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_res    = r_res;
                    n_out_status = r_status;
                    n_out_occ    = OCC_W'(r_count);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_new        <= n_new;
        r_cur        <= n_cur;
        r_best       <= n_best;
        r_best_idx   <= n_best_idx;
        r_best_child <= n_best_child;
        r_pos        <= n_pos;
        r_bidx       <= n_bidx;
        r_res        <= n_res;
        r_status     <= n_status;
        r_out_res    <= n_out_res;
        r_out_status <= n_out_status;
        r_out_occ    <= n_out_occ;
    end

endmodule

@@ design/bmhq_checker.sv @@
// Port-level checks for the heap queue unit, bound to its top level.
// Depends on bmhq_pkg and binary_min_heap_queue_unit_assert.svh.
`include "binary_min_heap_queue_unit_assert.svh"

module bmhq_checker
    import bmhq_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [KEY_W-1:0]  i_out_key,
    input logic [TAG_W-1:0]  i_out_tag,
    input logic [STAT_W-1:0] i_status,
    input logic [OCC_W-1:0]  i_occupancy
);

    // one item in flight: busy right after a transfer in
    `BMHQ_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    // a refused item returns no entry
    `BMHQ_ASSERT_IMPLY(a_err_no_entry, i_out_valid && (i_status != ST_OK),
                       (i_out_key == '0) && (i_out_tag == '0))

    `BMHQ_ASSERT_IMPLY(a_empty_occ, i_out_valid && (i_status == ST_EMPTY),
                       i_occupancy == '0)

    `BMHQ_ASSERT_IMPLY(a_full_occ, i_out_valid && (i_status == ST_FULL),
                       i_occupancy == OCC_W'(CAPACITY))

    `BMHQ_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
                      i_out_valid && $stable(i_out_key) && $stable(i_out_tag)
                      && $stable(i_status) && $stable(i_occupancy))

endmodule

bind binary_min_heap_queue_unit bmhq_checker #(
    .CAPACITY (CAPACITY)
) u_bmhq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_key   (o_res.out_key),
    .i_out_tag   (o_res.out_tag),
    .i_status    (o_res.status),
    .i_occupancy (o_res.occupancy)
);

@@ bench/tb_binary_min_heap_queue_unit.sv @@
// Testbench for binary_min_heap_queue_unit: directed and random heap operations with a
// cycle-free heap tracker that predicts every result and checks it in arrival order.
// Depends on bmhq_pkg, bmhq_if and the unit itself.
module tb_binary_min_heap_queue_unit
    import bmhq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAP        = CAPACITY_DEF;
    localparam int          ITEMS      = 1800;
    localparam int          QUIET_FROM = 1500;
    localparam int          STUCK_MAX  = 20000;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        t_status          status;
        logic [OCC_W-1:0] occ;
    } t_heap_reply;

    class heap_tracker;
        logic [KEY_W-1:0] keys [CAP];
        logic [TAG_W-1:0] tags [CAP];
        int unsigned      held;
        t_heap_reply      pending [$];
        int               errors;

        function void exchange(int unsigned a, int unsigned b);
            logic [KEY_W-1:0] k;
            logic [TAG_W-1:0] t;
            k = keys[a];
            t = tags[a];
            keys[a] = keys[b];
            tags[a] = tags[b];
            keys[b] = k;
            tags[b] = t;
        endfunction

        function void sink(int unsigned pos);
            int unsigned best, lc, rc;
            while (pos < held) begin
                best = pos;
                lc = 2 * pos + 1;
                rc = lc + 1;
                if (lc < held && keys[lc] < keys[best]) best = lc;
                if (rc < held && keys[rc] < keys[best]) best = rc;
                if (best == pos) break;
                exchange(best, pos);
                pos = best;
            end
        endfunction

        function void rise(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
            int unsigned pos, parent;
            pos = held;
            held++;
            while (pos != 0) begin
                parent = (pos - 1) / 2;
                if (!(key < keys[parent])) break;
                keys[pos] = keys[parent];
                tags[pos] = tags[parent];
                pos = parent;
            end
            keys[pos] = key;
            tags[pos] = tag;
        endfunction

        function void take_request(t_kind kind, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
            t_heap_reply r;
            int unsigned i;
            r = '0;
            r.status = ST_OK;
            case (kind)
                KIND_INSERT, KIND_LOAD: begin
                    if (held >= CAP) begin
                        r.status = ST_FULL;
                    end else if (kind == KIND_INSERT) begin
                        rise(key, tag);
                    end else begin
                        keys[held] = key;
                        tags[held] = tag;
                        held++;
                    end
                end
                KIND_EXTRACT: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.key = keys[0];
                        r.tag = tags[0];
                        held--;
                        keys[0] = keys[held];
                        tags[0] = tags[held];
                        sink(0);
                    end
                end
                default: begin
                    for (i = held / 2; i > 0; i--) sink(i - 1);
                end
            endcase
            r.occ = held[OCC_W-1:0];
            pending.push_back(r);
        endfunction

        function void match_result(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                                   logic [STAT_W-1:0] status, logic [OCC_W-1:0] occ);
            t_heap_reply want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result key %h tag %h status %0d occupancy %0d",
                         $realtime, key, tag, status, occ);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (key !== want.key) begin
                $display("%0t: out_key expected %h actual %h", $realtime, want.key, key);
                errors++;
            end
            if (tag !== want.tag) begin
                $display("%0t: out_tag expected %h actual %h", $realtime, want.tag, tag);
                errors++;
            end
            if (status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $realtime, want.status, status);
                errors++;
            end
            if (occ !== want.occ) begin
                $display("%0t: occupancy expected %0d actual %0d", $realtime, want.occ, occ);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bmhq_in_if  req_ch ();
    bmhq_out_if res_ch ();

    binary_min_heap_queue_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_res   (res_ch)
    );

    heap_tracker tracker = new();
    bit          quiet;
    int          issued;
    int          level;
    int          stuck;

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready)
                tracker.match_result(res_ch.out_key, res_ch.out_tag, res_ch.status,
                                     res_ch.occupancy);
            if (req_ch.valid && req_ch.ready)
                tracker.take_request(t_kind'(req_ch.kind), req_ch.key, req_ch.tag);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stuck <= 0;
        end else if (stuck >= STUCK_MAX) begin
            $display("FAILURE");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    // result side back-pressure
    initial begin
        int hold;
        hold = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && hold == 0 && $urandom_range(0, 19) == 0) hold = $urandom_range(1, 13);
            if (hold > 0) begin
                res_ch.ready = 1'b0;
                hold--;
            end else begin
                res_ch.ready = 1'b1;
            end
        end
    end

    task automatic push_request(t_kind kind, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
        int gap;
        if (!quiet && $urandom_range(0, 15) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge i_clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid = 1'b1;
        req_ch.kind  = kind;
        req_ch.key   = key;
        req_ch.tag   = tag;
        do @(posedge i_clk); while (!req_ch.ready);
        case (kind)
            KIND_INSERT, KIND_LOAD: if (level < CAP) level++;
            KIND_EXTRACT:           if (level > 0) level--;
            default: ;
        endcase
        issued++;
        quiet = (issued >= QUIET_FROM);
    endtask

    function automatic logic [KEY_W-1:0] draw_key(int mode);
        case (mode)
            0:       return $urandom;
            1:       return $urandom_range(0, 15);
            default: begin
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return '1;
                    2:       return 32'hFFFF_FFFE;
                    3:       return 32'h8000_0000;
                    default: return 32'd1;
                endcase
            end
        endcase
    endfunction

    function automatic logic [TAG_W-1:0] draw_tag();
        return $urandom_range(0, 65535);
    endfunction

    task automatic mixed_run(int mode);
        int n, pick;
        n = $urandom_range(10, 60);
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      push_request(KIND_INSERT, draw_key(mode), draw_tag());
            else if (pick < 85) push_request(KIND_EXTRACT, draw_key(mode), draw_tag());
            else if (pick < 95) push_request(KIND_LOAD, draw_key(mode), draw_tag());
            else                push_request(KIND_BUILD, draw_key(mode), draw_tag());
        end
    endtask

    task automatic load_and_build(int mode);
        int n;
        n = $urandom_range(1, 40);
        repeat (n) push_request(KIND_LOAD, draw_key(mode), draw_tag());
        push_request(KIND_BUILD, $urandom, draw_tag());
        repeat (n / 2 + 1) begin
            if ($urandom_range(0, 4) == 0) push_request(KIND_INSERT, draw_key(mode), draw_tag());
            else                           push_request(KIND_EXTRACT, $urandom, draw_tag());
        end
    endtask

    task automatic fill_up(int mode);
        bit unordered;
        unordered = $urandom_range(0, 1);
        while (level < CAP)
            push_request(unordered ? KIND_LOAD : KIND_INSERT, draw_key(mode), draw_tag());
        repeat ($urandom_range(1, 3))
            push_request($urandom_range(0, 1) ? KIND_LOAD : KIND_INSERT, draw_key(mode),
                         draw_tag());
        if (unordered) push_request(KIND_BUILD, $urandom, draw_tag());
    endtask

    task automatic drain();
        while (level > 0) push_request(KIND_EXTRACT, $urandom, draw_tag());
        push_request(KIND_EXTRACT, $urandom, draw_tag());
    endtask

    initial begin
        int seg, mode, fills;
        fills = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind  = KIND_INSERT;
        req_ch.key   = '0;
        req_ch.tag   = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty-heap corners, extremes, key ties, load/build
        push_request(KIND_EXTRACT, 32'hDEAD_BEEF, 16'hFFFF);
        push_request(KIND_BUILD, '0, '0);
        push_request(KIND_INSERT, '1, '1);
        push_request(KIND_BUILD, '0, '0);
        push_request(KIND_INSERT, '0, '0);
        push_request(KIND_INSERT, 32'd5, 16'd1);
        push_request(KIND_INSERT, 32'd5, 16'd2);
        push_request(KIND_INSERT, 32'd5, 16'd3);
        push_request(KIND_INSERT, 32'd3, 16'hA5A5);
        repeat (3) push_request(KIND_EXTRACT, '0, '0);
        push_request(KIND_LOAD, 32'd7, 16'd7);
        push_request(KIND_LOAD, 32'd2, 16'd20);
        push_request(KIND_LOAD, 32'd2, 16'd21);
        push_request(KIND_LOAD, 32'hFFFF_FFFE, 16'h5A5A);
        push_request(KIND_LOAD, 32'd1, 16'd1);
        push_request(KIND_BUILD, '1, '1);
        repeat (4) push_request(KIND_EXTRACT, '0, '0);

        while (issued < ITEMS) begin
            seg  = $urandom_range(0, 9);
            mode = $urandom_range(0, 9) < 5 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1);
            if (seg <= 3)                   mixed_run(mode);
            else if (seg <= 5)              load_and_build(mode);
            else if (seg == 6)              drain();
            else if (seg == 7 && fills < 2) begin
                fill_up(mode);
                fills++;
            end else begin
                repeat ($urandom_range(5, 20))
                    push_request(t_kind'($urandom_range(0, 3)), $urandom, draw_tag());
            end
        end

        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
